>>> sv/tbc_pkg.sv
// Shared types and constants for the triangle barycentric coordinate unit.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps

package tbc_pkg;

  // Fixed field and datapath widths
  localparam int CoordBits  = 12;
  localparam int DiffBits   = CoordBits + 1;        // vertex differences
  localparam int ProdBits   = 2 * DiffBits;         // one coordinate product
  localparam int DotBits    = ProdBits + 2;         // sum of three products
  localparam int GramBits   = 2 * DotBits;          // product of two dots
  localparam int WideBits   = GramBits + 1;         // determinant / numerators
  localparam int QuotBits   = 33;                   // quotient bits kept
  localparam int WeightBits = 32;
  localparam int ThrBits    = 20;
  localparam int AddrBits   = 3;
  localparam int DataBits   = 32;

  // Pipeline depths
  localparam int FrontLat = 5;
  localparam int DivLat   = QuotBits + 2;
  localparam int TotalLat = FrontLat + 1 + DivLat + 1;

  // Register map (word index)
  localparam logic RegThr = 1'b0;
  localparam logic [ThrBits-1:0] ThrReset = ThrBits'(1);

  typedef struct packed {
    logic signed [CoordBits-1:0] vert0_x;
    logic signed [CoordBits-1:0] vert0_y;
    logic signed [CoordBits-1:0] vert0_z;
    logic signed [CoordBits-1:0] vert1_x;
    logic signed [CoordBits-1:0] vert1_y;
    logic signed [CoordBits-1:0] vert1_z;
    logic signed [CoordBits-1:0] vert2_x;
    logic signed [CoordBits-1:0] vert2_y;
    logic signed [CoordBits-1:0] vert2_z;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
  } item_t;

  typedef struct packed {
    logic                         valid_res;
    logic signed [WeightBits-1:0] weight_u;
    logic signed [WeightBits-1:0] weight_v;
    logic signed [WeightBits-1:0] weight_w;
  } result_t;

  // Front-end output: determinant and both numerators
  typedef struct packed {
    logic signed [WideBits-1:0] den;
    logic signed [WideBits-1:0] num_v;
    logic signed [WideBits-1:0] num_w;
  } gram_t;

endpackage

>>> sv/tbc_front.sv
// Front end: edge vectors, dot products, determinant and numerators.
// Five register stages. Depends on tbc_pkg.
`timescale 1ns / 1ps

module tbc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  tbc_pkg::item_t item_i,
  output logic          valid_o,
  output tbc_pkg::gram_t gram_o
);

  localparam int DW = tbc_pkg::DiffBits;
  localparam int PW = tbc_pkg::ProdBits;
  localparam int TW = tbc_pkg::DotBits;
  localparam int GW = tbc_pkg::GramBits;
  localparam int WW = tbc_pkg::WideBits;

  logic [tbc_pkg::FrontLat-1:0] vld_q;

  // Stage 1: differences
  logic signed [DW-1:0] e0_d [3], e1_d [3], pq_d [3];
  logic signed [DW-1:0] e0_q [3], e1_q [3], pq_q [3];

  always_comb begin
    e0_d[0] = DW'(item_i.vert1_x) - DW'(item_i.vert0_x);
    e0_d[1] = DW'(item_i.vert1_y) - DW'(item_i.vert0_y);
    e0_d[2] = DW'(item_i.vert1_z) - DW'(item_i.vert0_z);
    e1_d[0] = DW'(item_i.vert2_x) - DW'(item_i.vert0_x);
    e1_d[1] = DW'(item_i.vert2_y) - DW'(item_i.vert0_y);
    e1_d[2] = DW'(item_i.vert2_z) - DW'(item_i.vert0_z);
    pq_d[0] = DW'(item_i.point_x) - DW'(item_i.vert0_x);
    pq_d[1] = DW'(item_i.point_y) - DW'(item_i.vert0_y);
    pq_d[2] = DW'(item_i.point_z) - DW'(item_i.vert0_z);
  end

  // Stage 2: per-coordinate products
  logic signed [PW-1:0] p00_q [3], p01_q [3], p11_q [3], p20_q [3], p21_q [3];

  // Stage 3: dot products
  logic signed [TW-1:0] d00_q, d01_q, d11_q, d20_q, d21_q;

  // Stage 4: dot-by-dot products
  logic signed [GW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;

  // Stage 5: determinant and numerators
  tbc_pkg::gram_t gram_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e0_q[i]  <= e0_d[i];
      e1_q[i]  <= e1_d[i];
      pq_q[i]  <= pq_d[i];
      p00_q[i] <= PW'(e0_q[i]) * PW'(e0_q[i]);
      p01_q[i] <= PW'(e0_q[i]) * PW'(e1_q[i]);
      p11_q[i] <= PW'(e1_q[i]) * PW'(e1_q[i]);
      p20_q[i] <= PW'(pq_q[i]) * PW'(e0_q[i]);
      p21_q[i] <= PW'(pq_q[i]) * PW'(e1_q[i]);
    end
    d00_q <= TW'(p00_q[0]) + TW'(p00_q[1]) + TW'(p00_q[2]);
    d01_q <= TW'(p01_q[0]) + TW'(p01_q[1]) + TW'(p01_q[2]);
    d11_q <= TW'(p11_q[0]) + TW'(p11_q[1]) + TW'(p11_q[2]);
    d20_q <= TW'(p20_q[0]) + TW'(p20_q[1]) + TW'(p20_q[2]);
    d21_q <= TW'(p21_q[0]) + TW'(p21_q[1]) + TW'(p21_q[2]);
    m0_q  <= GW'(d00_q) * GW'(d11_q);
    m1_q  <= GW'(d01_q) * GW'(d01_q);
    m2_q  <= GW'(d11_q) * GW'(d20_q);
    m3_q  <= GW'(d01_q) * GW'(d21_q);
    m4_q  <= GW'(d00_q) * GW'(d21_q);
    m5_q  <= GW'(d01_q) * GW'(d20_q);
    gram_q.den   <= WW'(m0_q) - WW'(m1_q);
    gram_q.num_v <= WW'(m2_q) - WW'(m3_q);
    gram_q.num_w <= WW'(m4_q) - WW'(m5_q);
  end

  // Valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[tbc_pkg::FrontLat-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[tbc_pkg::FrontLat-1];
  assign gram_o  = gram_q;

endmodule

>>> sv/tbc_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit
// per stage, signed and saturated to 32 bits at the end. Depends on tbc_pkg.
`timescale 1ns / 1ps

module tbc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [tbc_pkg::WideBits-1:0]          num_i,
  input  logic [tbc_pkg::WideBits-1:0]          den_i,
  input  logic                                  neg_i,
  output logic                                  valid_o,
  output logic signed [tbc_pkg::WeightBits-1:0] quot_o
);

  localparam int WW = tbc_pkg::WideBits;
  localparam int QB = tbc_pkg::QuotBits;
  localparam int RemBits = WW + FRAC_BITS;
  localparam int CmpBits = WW + QB;
  localparam int OW = tbc_pkg::WeightBits;

  logic [RemBits-1:0] rem_q [QB+1];
  logic [WW-1:0]      den_q [QB+1];
  logic [QB-1:0]      quo_q [QB+1];
  logic               neg_q [QB+1];
  logic               ovf_q [QB+1];
  logic [QB:0]        vld_q;

  // Stage 0: shifted numerator and overflow check against den << QB
  logic [RemBits-1:0] rem0;
  logic               ovf0;
  assign rem0 = RemBits'(num_i) << FRAC_BITS;
  assign ovf0 = CmpBits'(rem0) >= (CmpBits'(den_i) << QB);

  always_ff @(posedge clk_i) begin
    rem_q[0] <= rem0;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    neg_q[0] <= neg_i;
    ovf_q[0] <= ovf0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QB-1:0], valid_i};
    end
  end

  // Stages 1..QB: one trial subtract each, MSB first
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int Sh = QB - k;
    logic [CmpBits-1:0] trial;
    logic [CmpBits-1:0] diff;
    logic               take;

    assign trial = CmpBits'(den_q[k-1]) << Sh;
    assign diff  = CmpBits'(rem_q[k-1]) - trial;
    assign take  = CmpBits'(rem_q[k-1]) >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? diff[RemBits-1:0] : rem_q[k-1];
      quo_q[k] <= quo_q[k-1] | (take ? (QB'(1) << Sh) : '0);
      den_q[k] <= den_q[k-1];
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
  end

  // Output stage: clamp magnitude, apply sign
  logic [QB-1:0] lim, mag;
  logic [OW-1:0] res_d;
  logic signed [OW-1:0] res_q;
  logic          vld_out_q;

  always_comb begin
    lim = neg_q[QB] ? (QB'(1) << (OW - 1)) : ((QB'(1) << (OW - 1)) - QB'(1));
    mag = (ovf_q[QB] || (quo_q[QB] > lim)) ? lim : quo_q[QB];
    res_d = neg_q[QB] ? (OW'(0) - mag[OW-1:0]) : mag[OW-1:0];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[QB];
    end
  end

  assign valid_o = vld_out_q;
  assign quot_o  = res_q;

endmodule

>>> sv/triangle_barycentric_coords_unit.sv
// Top level of the triangle barycentric coordinate unit: config register,
// sign/degenerate stage, two dividers, weight assembly. Uses tbc_pkg,
// tbc_front and tbc_div.
`timescale 1ns / 1ps
//
//  channel   signals                              direction  handshake
//  item      start, busy, item_i                  in         start && !busy
//  result    done_o, result_o                     out        done_o, one cycle
//  config    psel..pwdata, prdata, pready         in/out     APB, pready tied high
//
//  One item per cycle; busy is never raised. The pipeline holds five
//  front-end stages, one sign stage, 35 divider stages (one quotient bit
//  per trial-subtract stage, 33 bits) and the output register.
//  Reset clears valid bits and restores the threshold to 1. The receiver
//  cannot stall, so nothing in the pipeline ever holds.

module triangle_barycentric_coords_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tbc_pkg::item_t                 item_i,
  output logic                           done_o,
  output tbc_pkg::result_t               result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tbc_pkg::AddrBits-1:0]   paddr,
  input  logic [tbc_pkg::DataBits-1:0]   pwdata,
  output logic [tbc_pkg::DataBits-1:0]   prdata,
  output logic                           pready
);

  localparam int WW = tbc_pkg::WideBits;
  localparam int OW = tbc_pkg::WeightBits;
  localparam int TB = tbc_pkg::ThrBits;
  localparam int SumBits = OW + 2;

  // Config register
  logic [TB-1:0] thr_q, thr_d;
  logic          reg_sel;

  assign reg_sel = paddr[tbc_pkg::AddrBits-1] == tbc_pkg::RegThr;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? tbc_pkg::DataBits'(thr_q) : '0;

  always_comb begin
    thr_d = thr_q;
    if (psel && penable && pwrite && reg_sel) begin
      thr_d = pwdata[TB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tbc_pkg::ThrReset;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign busy = 1'b0;

  // Front end
  logic           fr_valid;
  tbc_pkg::gram_t fr_gram;

  tbc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .valid_o (fr_valid),
    .gram_o  (fr_gram)
  );

  // Sign stage: magnitudes, quotient signs, degenerate test
  logic [WW-1:0] aden, anv, anw;
  logic [WW-1:0] aden_q, anv_q, anw_q;
  logic          negv_q, negw_q, degen_q, sgn_vld_q;
  logic          dn, vn, wn;

  always_comb begin
    dn   = fr_gram.den[WW-1];
    vn   = fr_gram.num_v[WW-1];
    wn   = fr_gram.num_w[WW-1];
    aden = dn ? (WW'(0) - fr_gram.den)   : fr_gram.den;
    anv  = vn ? (WW'(0) - fr_gram.num_v) : fr_gram.num_v;
    anw  = wn ? (WW'(0) - fr_gram.num_w) : fr_gram.num_w;
  end

  always_ff @(posedge clk_i) begin
    aden_q  <= aden;
    anv_q   <= anv;
    anw_q   <= anw;
    negv_q  <= vn ^ dn;
    negw_q  <= wn ^ dn;
    degen_q <= (aden == '0) || (aden < WW'(thr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sgn_vld_q <= 1'b0;
    end else begin
      sgn_vld_q <= fr_valid;
    end
  end

  // Dividers
  logic                 dv_valid, dw_valid;
  logic signed [OW-1:0] quot_v, quot_w;

  tbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sgn_vld_q),
    .num_i   (anv_q),
    .den_i   (aden_q),
    .neg_i   (negv_q),
    .valid_o (dv_valid),
    .quot_o  (quot_v)
  );

  tbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_w (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sgn_vld_q),
    .num_i   (anw_q),
    .den_i   (aden_q),
    .neg_i   (negw_q),
    .valid_o (dw_valid),
    .quot_o  (quot_w)
  );

  // Degenerate flag rides alongside the dividers
  logic degen_line_q [tbc_pkg::DivLat];

  always_ff @(posedge clk_i) begin
    degen_line_q[0] <= degen_q;
    for (int i = 1; i < tbc_pkg::DivLat; i++) begin
      degen_line_q[i] <= degen_line_q[i-1];
    end
  end

  // Output stage: u = 1 - v - w, saturated; zero on degenerate
  logic signed [SumBits-1:0] usum;
  logic signed [OW-1:0]      u_sat;
  tbc_pkg::result_t          res_d, res_q;
  logic                      done_q;
  logic                      degen_out;

  assign degen_out = degen_line_q[tbc_pkg::DivLat-1];

  always_comb begin
    usum = (SumBits'(1) <<< FRAC_BITS) - SumBits'(quot_v) - SumBits'(quot_w);
    if (usum > ((SumBits'(1) <<< (OW - 1)) - SumBits'(1))) begin
      u_sat = {1'b0, {(OW-1){1'b1}}};
    end else if (usum < -(SumBits'(1) <<< (OW - 1))) begin
      u_sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      u_sat = usum[OW-1:0];
    end
    if (degen_out) begin
      res_d = '0;
    end else begin
      res_d.valid_res = 1'b1;
      res_d.weight_u  = u_sat;
      res_d.weight_v  = quot_v;
      res_d.weight_w  = quot_w;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  // Both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid == dw_valid) else $error("divider valid bits disagree");

  // Every accepted item comes out as a done_o pulse
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(tbc_pkg::TotalLat) done_o)
    else $error("item lost in pipeline");

  // No result without an earlier accepted item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, tbc_pkg::TotalLat))
    else $error("result without item");
`endif

endmodule
